/* rtl/afcp_pkg.sv */
package afcp_pkg;

	// Framing characters
	localparam logic [7:0] CH_OPEN = 8'h63;  // 'c'
	localparam logic [7:0] CH_DOT  = 8'h2E;  // '.'
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;

	// Most body bytes passed on per frame (1 to 255)
	localparam logic [7:0] MAX_BODY = 8'd255;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_BODY = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	// Checksum collection phase
	typedef enum logic [1:0] {
		PH_NONE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	// Nibble value of a bad hex character; never equals a 4-bit nibble
	localparam logic [4:0] NIBBLE_BAD = 5'd16;

	typedef struct packed {
		logic       frame_open;
		logic [7:0] body_count;
		phase_t     phase;
		logic [7:0] running_xor;
		logic [7:0] check_high;
		logic [7:0] check_low;
	} frame_state_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] body_byte;
		logic [7:0] frame_length;
	} frame_result_t;

	// Upper-case hex character to nibble, NIBBLE_BAD otherwise
	function automatic logic [4:0] hex_value(input logic [7:0] ch);
		logic [4:0] v;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			v = {1'b0, ch[3:0]};
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			v = 5'(ch[3:0] + 4'd9);
		end else begin
			v = NIBBLE_BAD;
		end
		return v;
	endfunction

endpackage

/* rtl/afcp_step.sv */
module afcp_step import afcp_pkg::*; (
	input  frame_state_t  cur,
	input  logic [7:0]    rx_byte,
	output frame_state_t  nxt,
	output frame_result_t res
);

	logic good;

	// Verdict for a closing CR or LF
	always_comb begin
		good = 1'b0;
		if (cur.body_count != 8'd0 && cur.phase == PH_DONE) begin
			good = (hex_value(cur.check_high) == {1'b0, cur.running_xor[7:4]}) &&
			       (hex_value(cur.check_low) == {1'b0, cur.running_xor[3:0]});
		end
	end

	// One byte of the frame state machine
	always_comb begin
		nxt              = cur;
		res.valid        = 1'b0;
		res.kind         = KIND_BODY;
		res.body_byte    = 8'd0;
		res.frame_length = cur.body_count;

		if (rx_byte == CH_OPEN) begin
			// open aborts any frame in progress
			res.valid       = cur.frame_open;
			res.kind        = KIND_BAD;
			nxt.frame_open  = 1'b1;
			nxt.body_count  = 8'd0;
			nxt.phase       = PH_NONE;
			nxt.running_xor = 8'd0;
		end else if (cur.frame_open) begin
			if (rx_byte == CH_CR || rx_byte == CH_LF) begin
				res.valid      = 1'b1;
				res.kind       = good ? KIND_GOOD : KIND_BAD;
				nxt.frame_open = 1'b0;
				nxt.body_count = 8'd0;
				nxt.phase      = PH_NONE;
			end else if (rx_byte == CH_DOT) begin
				nxt.phase = PH_HIGH;
			end else begin
				case (cur.phase)
					PH_HIGH: begin
						nxt.check_high = rx_byte;
						nxt.phase      = PH_LOW;
					end
					PH_LOW: begin
						nxt.check_low = rx_byte;
						nxt.phase     = PH_DONE;
					end
					PH_DONE: begin
						// extra checksum characters ignored
					end
					default: begin
						// body byte, dropped once the body is full
						if (cur.body_count < MAX_BODY) begin
							nxt.body_count   = cur.body_count + 8'd1;
							nxt.running_xor  = cur.running_xor ^ rx_byte;
							res.valid        = 1'b1;
							res.kind         = KIND_BODY;
							res.body_byte    = rx_byte;
							res.frame_length = cur.body_count + 8'd1;
						end
					end
				endcase
			end
		end
	end

endmodule

/* rtl/ascii_frame_checksum_parser.sv */
// A result passes through the input register, then the result register.
// Throughput: one byte per cycle, sustained while the output is taken.
// Bytes that cause no result are absorbed without an output request.
// Reset (arst_n low, asynchronous): no frame open, counters and XOR cleared.
module ascii_frame_checksum_parser import afcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] body_byte, [15:8] frame_length
	output logic [1:0]  m_axis_tuser    // [1:0] kind
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          out_valid_q;
	kind_t         kind_q;
	logic [7:0]    body_byte_q;
	logic [7:0]    frame_length_q;
	frame_state_t  state_q;
	frame_state_t  state_nxt;
	frame_result_t res;
	logic          advance;

	// Stage 1 moves on when the result register is free or being emptied
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	afcp_step u_step (
		.cur     (state_q),
		.rx_byte (byte_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.valid) begin
			kind_q         <= res.kind;
			body_byte_q    <= res.body_byte;
			frame_length_q <= res.frame_length;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {frame_length_q, body_byte_q};
	assign m_axis_tuser  = kind_q;

endmodule

/* bench/tb.sv */
module tb;
	import afcp_pkg::*;

	// One result as the parser should present it
	typedef struct packed {
		kind_t      kind;
		logic [7:0] body_byte;
		logic [7:0] frame_length;
	} frame_event_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [7:0] body_byte, [15:8] frame_length
	logic [1:0]  m_axis_tuser;           // [1:0] kind

	// Stall mix, in percent of cycles
	int tx_idle_pct = 6;
	int rx_idle_pct = 74;

	int mismatches     = 0;
	int events_checked = 0;
	int bytes_sent     = 0;
	int frames_good    = 0;
	int frames_bad     = 0;

	// Local copy of the parser state
	logic       frame_is_open = 1'b0;
	logic [7:0] body_total    = 8'h00;
	phase_t     sum_phase     = PH_NONE;
	logic [7:0] body_xor      = 8'h00;
	logic [7:0] sum_high_char = 8'h00;
	logic [7:0] sum_low_char  = 8'h00;

	frame_event_t events_due[$];
	frame_event_t want_ev;

	ascii_frame_checksum_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Hard stop
	initial begin
		#1000000;
		$display("timeout: %0d results still due", events_due.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Upper-case hex digit to its value; anything else decodes out of nibble range
	function automatic logic [4:0] nibble_of(input logic [7:0] ch);
		if (ch inside {[8'h30:8'h39]})
			return 5'(ch - 8'h30);
		if (ch inside {[8'h41:8'h46]})
			return 5'(ch - 8'h37);
		return NIBBLE_BAD;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'(8'h30 + n) : 8'(8'h37 + n);
	endfunction

	// Random byte that the parser treats as plain body or checksum text
	function automatic logic [7:0] body_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_OPEN || b == CH_DOT || b == CH_CR || b == CH_LF);
		return b;
	endfunction

	// Advance the local parser by one accepted byte and queue what it emits
	task automatic parse_rx_byte(input logic [7:0] ch);
		frame_event_t ev;
		logic         verdict;
		ev.body_byte = 8'h00;
		if (ch == CH_OPEN) begin
			// reopening inside a frame abandons the old one
			if (frame_is_open) begin
				ev.kind         = KIND_BAD;
				ev.frame_length = body_total;
				events_due.push_back(ev);
				frames_bad++;
			end
			frame_is_open = 1'b1;
			body_total    = 8'h00;
			sum_phase     = PH_NONE;
			body_xor      = 8'h00;
		end else if (frame_is_open) begin
			if (ch == CH_CR || ch == CH_LF) begin
				verdict = body_total != 8'h00 && sum_phase == PH_DONE &&
					nibble_of(sum_high_char) == {1'b0, body_xor[7:4]} &&
					nibble_of(sum_low_char) == {1'b0, body_xor[3:0]};
				ev.kind         = verdict ? KIND_GOOD : KIND_BAD;
				ev.frame_length = body_total;
				events_due.push_back(ev);
				if (verdict)
					frames_good++;
				else
					frames_bad++;
				frame_is_open = 1'b0;
				body_total    = 8'h00;
				sum_phase     = PH_NONE;
			end else if (ch == CH_DOT) begin
				sum_phase = PH_HIGH;
			end else begin
				case (sum_phase)
					PH_HIGH: begin
						sum_high_char = ch;
						sum_phase     = PH_LOW;
					end
					PH_LOW: begin
						sum_low_char = ch;
						sum_phase    = PH_DONE;
					end
					PH_DONE: begin
						// trailing text before the terminator is dropped
					end
					default: begin
						if (body_total < MAX_BODY) begin
							body_total      = body_total + 8'd1;
							body_xor        = body_xor ^ ch;
							ev.kind         = KIND_BODY;
							ev.body_byte    = ch;
							ev.frame_length = body_total;
							events_due.push_back(ev);
						end
					end
				endcase
			end
		end
	endtask

	// Offer one byte, with random idle cycles ahead of the request
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		parse_rx_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Result side: random back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Compare each taken result with the oldest one due
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (events_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: kind %0d byte %02h length %0d",
						m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
				mismatches++;
			end else begin
				want_ev = events_due.pop_front();
				events_checked++;
				if (m_axis_tuser !== want_ev.kind || m_axis_tdata[7:0] !== want_ev.body_byte ||
					m_axis_tdata[15:8] !== want_ev.frame_length) begin
					if (mismatches < 10)
						$display("mismatch: want kind %0d byte %02h length %0d, got kind %0d byte %02h length %0d",
							want_ev.kind, want_ev.body_byte, want_ev.frame_length,
							m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
					mismatches++;
				end
			end
		end
	end

	// Bytes with no frame open are absorbed silently
	task automatic test_idle_line_bytes();
		send_byte(CH_CR);
		send_byte(CH_DOT);
		send_byte(8'hFF);
		send_byte(CH_LF);
	endtask

	// Body byte extremes, then a reopen that abandons the frame
	task automatic test_body_extremes();
		send_byte(CH_OPEN);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_OPEN);
	endtask

	// Verdict paths: restarted period with trailing text, bad hex, empty body, no checksum
	task automatic test_checksum_cases();
		send_text("B.9.42X");
		send_byte(CH_LF);
		send_text("cA.G1");
		send_byte(CH_CR);
		send_text("c.00");
		send_byte(CH_CR);
		send_text("cZ.");
		send_byte(CH_LF);
	endtask

	// Frame longer than the body limit: extra bytes dropped, length saturates
	task automatic test_body_overflow();
		logic [7:0] b;
		logic [7:0] sum;
		sum = 8'h00;
		send_byte(CH_OPEN);
		for (int i = 0; i < 258; i++) begin
			b = body_char();
			if (i < 255)
				sum = sum ^ b;
			send_byte(b);
		end
		send_byte(CH_DOT);
		send_byte(hex_char(sum[7:4]));
		send_byte(hex_char(sum[3:0]));
		send_byte(CH_CR);
	endtask

	// Mostly well-formed frame with random content and a varied tail
	task automatic send_random_frame();
		logic [7:0] b;
		logic [7:0] sum;
		int         n;
		int         tail;
		sum = 8'h00;
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
		tail = $urandom_range(0, 99);
		send_byte(CH_OPEN);
		repeat (n) begin
			b = body_char();
			sum = sum ^ b;
			send_byte(b);
		end
		if (tail < 95)
			send_byte(CH_DOT);
		if (tail < 70) begin
			send_byte(hex_char(sum[7:4]));
			send_byte(hex_char(sum[3:0]));
		end else if (tail < 76) begin
			send_byte(body_char());
			send_byte(CH_DOT);
			send_byte(hex_char(sum[7:4]));
			send_byte(hex_char(sum[3:0]));
		end else if (tail < 82) begin
			send_byte(hex_char(sum[7:4]));
			send_byte(hex_char(sum[3:0]));
			repeat ($urandom_range(1, 3))
				send_byte(body_char());
		end else if (tail < 90) begin
			// corrupt one of the two digits
			if ($urandom_range(0, 1) == 0) begin
				send_byte(body_char());
				send_byte(hex_char(sum[3:0]));
			end else begin
				send_byte(hex_char(sum[7:4]));
				send_byte(hex_char(sum[3:0] ^ 4'(($urandom_range(1, 15)))));
			end
		end else if (tail < 95) begin
			if ($urandom_range(0, 1) == 0)
				send_byte(hex_char(sum[7:4]));
		end
		// tails 97 and 98 send no terminator, leaving the frame open
		if (tail < 97 || tail >= 99)
			send_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 7))
				0:       send_byte(CH_OPEN);
				1:       send_byte(CH_DOT);
				2:       send_byte(CH_CR);
				3:       send_byte(CH_LF);
				default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic test_random_traffic(input int n_bytes);
		int target;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			if ($urandom_range(0, 99) < 80)
				send_random_frame();
			else
				send_noise();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// receiver stalls heavily
		tx_idle_pct = 6;
		rx_idle_pct = 74;
		test_idle_line_bytes();
		test_body_extremes();
		test_checksum_cases();
		test_body_overflow();
		test_random_traffic(400);

		// sender gaps heavily
		tx_idle_pct = 74;
		rx_idle_pct = 6;
		test_random_traffic(430);

		// full rate both ways
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(430);

		s_axis_tvalid <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d bytes sent, %0d results checked, %0d frames good, %0d bad or abandoned",
			bytes_sent, events_checked, frames_good, frames_bad);
		$display("covered idle-line bytes, reopen, checksum restarts, bad hex, body overflow, three stall mixes");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
